// ----- rtl/bcds_pkg.sv -----
package bcds_pkg;

	// Default timer width
	localparam int TIMER_WIDTH_DEF = 16;

	// Phase codes, also the mode output
	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_CHG      = 3'd1;
	localparam logic [2:0] PH_DIS      = 3'd2;
	localparam logic [2:0] PH_CHG_DONE = 3'd3;
	localparam logic [2:0] PH_DIS_DONE = 3'd4;

	// Event codes
	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_OVERVOLT = 3'd1;
	localparam logic [2:0] EV_CHG_DONE = 3'd2;
	localparam logic [2:0] EV_UNDERVLT = 3'd3;
	localparam logic [2:0] EV_DIS_DONE = 3'd4;

	// Confirm timer slots
	localparam int CF_OVERVOLT = 0;
	localparam int CF_CHG_DONE = 1;
	localparam int CF_UNDERVLT = 2;
	localparam int CF_DIS_DONE = 3;
	localparam int CF_COUNT    = 4;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_TYPE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_CONFIRM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CPLT_CONFIRM  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_FLOOR = 3'd4;

	// Configuration reset values
	localparam logic [1:0]  RST_BATTERY_TYPE  = 2'd0;
	localparam logic [15:0] RST_HOLDOFF       = 16'd50000;
	localparam logic [15:0] RST_LIMIT_CONFIRM = 16'd50000;
	localparam logic [15:0] RST_CPLT_CONFIRM  = 16'd30000;
	localparam logic [15:0] RST_CURRENT_FLOOR = 16'd300;

	// Latched limit reset values
	localparam logic [15:0] RST_OVER_VOLT  = 16'd21000;
	localparam logic [15:0] RST_UNDER_VOLT = 16'd16000;
	localparam logic [15:0] RST_PWM_DUTY   = 16'd1200;

	typedef struct packed {
		logic [1:0]  battery_type;
		logic [15:0] holdoff_ms;
		logic [15:0] limit_confirm_ms;
		logic [15:0] complete_confirm_ms;
		logic [15:0] current_floor_ma;
	} cfg_t;

	typedef struct packed {
		logic [15:0] bat_volt_mv;
		logic [15:0] chg_current_ma;
		logic [15:0] dis_current_ma;
		logic        req_start_charge;
		logic        req_stop_charge;
		logic        req_start_discharge;
		logic        req_stop_discharge;
	} item_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic        charge_on;
		logic        discharge_on;
		logic        fan_on;
		logic        charge_led;
		logic        discharge_led;
		logic        charge_volt_sel;
		logic [15:0] charge_pwm_duty;
		logic [2:0]  event_res;
	} result_t;

	typedef struct packed {
		logic        keep;
		logic        volt_sel;
		logic [15:0] chg_duty;
		logic [15:0] over_volt;
		logic [15:0] under_volt;
	} type_lim_t;

	// Per battery type limits; type 3 keeps the previous limits and duty
	function automatic type_lim_t type_limits(input logic [1:0] battery_type);
		type_lim_t lim;
		unique case (battery_type)
			2'd0: lim = '{1'b0, 1'b0, 16'd24000, 16'd21500, 16'd12000};
			2'd1: lim = '{1'b0, 1'b1, 16'd6000, 16'd17500, 16'd10000};
			2'd2: lim = '{1'b0, 1'b1, 16'd6000, 16'd15000, 16'd8500};
			default: lim = '{1'b1, 1'b0, 16'd0, 16'd0, 16'd0};
		endcase
		return lim;
	endfunction

endpackage

// ----- rtl/bcds_cfg_regs.sv -----
module bcds_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bcds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	output bcds_pkg::cfg_t                 cfg
);

	bcds_pkg::cfg_t cfg_q;

	// Always take a write transfer
	assign cfg_ready = 1'b1;
	assign cfg        = cfg_q;

	// Decode the register index; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.battery_type        <= bcds_pkg::RST_BATTERY_TYPE;
			cfg_q.holdoff_ms          <= bcds_pkg::RST_HOLDOFF;
			cfg_q.limit_confirm_ms    <= bcds_pkg::RST_LIMIT_CONFIRM;
			cfg_q.complete_confirm_ms <= bcds_pkg::RST_CPLT_CONFIRM;
			cfg_q.current_floor_ma    <= bcds_pkg::RST_CURRENT_FLOOR;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bcds_pkg::CFG_BATTERY_TYPE:  cfg_q.battery_type <= cfg_data[1:0];
				bcds_pkg::CFG_HOLDOFF:       cfg_q.holdoff_ms <= cfg_data;
				bcds_pkg::CFG_LIMIT_CONFIRM: cfg_q.limit_confirm_ms <= cfg_data;
				bcds_pkg::CFG_CPLT_CONFIRM:  cfg_q.complete_confirm_ms <= cfg_data;
				bcds_pkg::CFG_CURRENT_FLOOR: cfg_q.current_floor_ma <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/bcds_confirm.sv -----
module bcds_confirm #(
	parameter int TIMER_WIDTH = bcds_pkg::TIMER_WIDTH_DEF
) (
	input  logic                   cond,
	input  logic                   waiting,
	input  logic [TIMER_WIDTH-1:0] timer,
	input  logic [15:0]            limit,
	output logic                   nxt_waiting,
	output logic [TIMER_WIDTH-1:0] nxt_timer,
	output logic                   fire
);

	logic [TIMER_WIDTH-1:0] timer_inc;

	// Saturating increment
	assign timer_inc = (timer == {TIMER_WIDTH{1'b1}}) ? timer : timer + TIMER_WIDTH'(1);

	// Arm on the first tick, count after, fire and clear at the limit
	always_comb begin
		nxt_waiting = 1'b0;
		nxt_timer   = '0;
		fire        = 1'b0;
		if (cond) begin
			if (!waiting) begin
				nxt_waiting = 1'b1;
			end else if (timer_inc >= TIMER_WIDTH'(limit)) begin
				fire = 1'b1;
			end else begin
				nxt_waiting = 1'b1;
				nxt_timer   = timer_inc;
			end
		end
	end

endmodule

// ----- rtl/bcds_core.sv -----
module bcds_core #(
	parameter int TIMER_WIDTH = bcds_pkg::TIMER_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  bcds_pkg::item_t   item,
	input  bcds_pkg::cfg_t    cfg,
	output bcds_pkg::result_t res
);

	localparam int NCF = bcds_pkg::CF_COUNT;

	// Supervisor state
	logic [2:0]             phase_q;
	logic [15:0]            ov_q;
	logic [15:0]            uv_q;
	logic [15:0]            duty_q;
	logic                   vsel_q;
	logic                   led_c_q;
	logic                   led_d_q;
	logic [TIMER_WIDTH-1:0] elapsed_q;
	logic [NCF-1:0]         wait_q;
	logic [TIMER_WIDTH-1:0] tmr_q [NCF];

	// Next values
	logic [2:0]             ph_req;
	logic                   fresh;
	logic [15:0]            ov_n;
	logic [15:0]            uv_n;
	logic [15:0]            duty_n;
	logic                   vsel_n;
	bcds_pkg::type_lim_t    lim;
	logic [2:0]             phase_n;
	logic [2:0]             ev_n;
	logic                   led_c_n;
	logic                   led_d_n;
	logic [TIMER_WIDTH-1:0] elapsed_n;
	logic [TIMER_WIDTH-1:0] elapsed_inc;
	logic [NCF-1:0]         wait_n;
	logic [TIMER_WIDTH-1:0] tmr_n [NCF];

	// Confirm cell connections
	logic [NCF-1:0]         base_wait;
	logic [TIMER_WIDTH-1:0] base_tmr [NCF];
	logic [NCF-1:0]         cf_cond;
	logic [15:0]            cf_limit [NCF];
	logic [NCF-1:0]         cf_wait;
	logic [TIMER_WIDTH-1:0] cf_tmr [NCF];
	logic [NCF-1:0]         cf_fire;
	logic                   checks_on;

	assign lim = bcds_pkg::type_limits(cfg.battery_type);

	// Handle requests in order: stop discharge, stop charge, start charge, start discharge
	always_comb begin
		ph_req = phase_q;
		fresh  = 1'b0;
		ov_n   = ov_q;
		uv_n   = uv_q;
		duty_n = duty_q;
		vsel_n = vsel_q;
		if (item.req_stop_discharge &&
		    (ph_req == bcds_pkg::PH_DIS || ph_req == bcds_pkg::PH_DIS_DONE)) begin
			ph_req = bcds_pkg::PH_IDLE;
		end
		if (item.req_stop_charge &&
		    (ph_req == bcds_pkg::PH_CHG || ph_req == bcds_pkg::PH_CHG_DONE)) begin
			ph_req = bcds_pkg::PH_IDLE;
		end
		if (item.req_start_charge && ph_req == bcds_pkg::PH_IDLE) begin
			vsel_n = lim.volt_sel;
			if (!lim.keep) begin
				ov_n   = lim.over_volt;
				uv_n   = lim.under_volt;
				duty_n = lim.chg_duty;
			end
			ph_req = bcds_pkg::PH_CHG;
			fresh  = 1'b1;
		end
		if (item.req_start_discharge && ph_req == bcds_pkg::PH_IDLE) begin
			ph_req = bcds_pkg::PH_DIS;
			fresh  = 1'b1;
		end
	end

	// A start clears the confirm timers before they are evaluated
	assign base_wait = fresh ? '0 : wait_q;

	// Confirm conditions per slot, against the limits latched on this tick
	assign cf_cond[bcds_pkg::CF_OVERVOLT] = (item.bat_volt_mv >= ov_n) &&
		(item.chg_current_ma > cfg.current_floor_ma);
	assign cf_cond[bcds_pkg::CF_CHG_DONE] = (item.chg_current_ma <= cfg.current_floor_ma);
	assign cf_cond[bcds_pkg::CF_UNDERVLT] = (item.bat_volt_mv <= uv_q) &&
		(item.dis_current_ma > cfg.current_floor_ma);
	assign cf_cond[bcds_pkg::CF_DIS_DONE] = (item.dis_current_ma <= cfg.current_floor_ma);

	assign cf_limit[bcds_pkg::CF_OVERVOLT] = cfg.limit_confirm_ms;
	assign cf_limit[bcds_pkg::CF_CHG_DONE] = cfg.complete_confirm_ms;
	assign cf_limit[bcds_pkg::CF_UNDERVLT] = cfg.limit_confirm_ms;
	assign cf_limit[bcds_pkg::CF_DIS_DONE] = cfg.complete_confirm_ms;

	genvar gi;
	generate
		for (gi = 0; gi < NCF; gi++) begin : g_cf
			assign base_tmr[gi] = fresh ? '0 : tmr_q[gi];

			bcds_confirm #(
				.TIMER_WIDTH (TIMER_WIDTH)
			) u_confirm (
				.cond        (cf_cond[gi]),
				.waiting     (base_wait[gi]),
				.timer       (base_tmr[gi]),
				.limit       (cf_limit[gi]),
				.nxt_waiting (cf_wait[gi]),
				.nxt_timer   (cf_tmr[gi]),
				.fire        (cf_fire[gi])
			);
		end
	endgenerate

	// Advance the phase clock, saturating
	assign elapsed_inc = (elapsed_q == {TIMER_WIDTH{1'b1}}) ?
		elapsed_q : elapsed_q + TIMER_WIDTH'(1);

	always_comb begin
		elapsed_n = elapsed_q;
		if (fresh) begin
			elapsed_n = '0;
		end else if (ph_req == bcds_pkg::PH_CHG || ph_req == bcds_pkg::PH_DIS) begin
			elapsed_n = elapsed_inc;
		end
	end

	assign checks_on = (elapsed_n >= TIMER_WIDTH'(cfg.holdoff_ms));

	// Run the phase: lamps, confirm timers and completion
	always_comb begin
		phase_n = ph_req;
		ev_n    = bcds_pkg::EV_NONE;
		led_c_n = led_c_q;
		led_d_n = led_d_q;
		wait_n  = base_wait;
		tmr_n   = base_tmr;
		unique case (ph_req)
			bcds_pkg::PH_IDLE: begin
				led_c_n = 1'b0;
				led_d_n = 1'b0;
				wait_n  = '0;
				for (int k = 0; k < NCF; k++) begin
					tmr_n[k] = '0;
				end
			end
			bcds_pkg::PH_CHG: begin
				led_c_n = 1'b1;
				led_d_n = 1'b0;
				if (checks_on) begin
					wait_n[bcds_pkg::CF_OVERVOLT] = cf_wait[bcds_pkg::CF_OVERVOLT];
					wait_n[bcds_pkg::CF_CHG_DONE] = cf_wait[bcds_pkg::CF_CHG_DONE];
					tmr_n[bcds_pkg::CF_OVERVOLT]  = cf_tmr[bcds_pkg::CF_OVERVOLT];
					tmr_n[bcds_pkg::CF_CHG_DONE]  = cf_tmr[bcds_pkg::CF_CHG_DONE];
					if (cf_fire[bcds_pkg::CF_OVERVOLT]) begin
						phase_n = bcds_pkg::PH_IDLE;
						ev_n    = bcds_pkg::EV_OVERVOLT;
					end
					if (cf_fire[bcds_pkg::CF_CHG_DONE]) begin
						phase_n = bcds_pkg::PH_CHG_DONE;
						ev_n    = bcds_pkg::EV_CHG_DONE;
					end
				end
			end
			bcds_pkg::PH_DIS: begin
				led_c_n = 1'b0;
				led_d_n = 1'b1;
				if (checks_on) begin
					wait_n[bcds_pkg::CF_UNDERVLT] = cf_wait[bcds_pkg::CF_UNDERVLT];
					wait_n[bcds_pkg::CF_DIS_DONE] = cf_wait[bcds_pkg::CF_DIS_DONE];
					tmr_n[bcds_pkg::CF_UNDERVLT]  = cf_tmr[bcds_pkg::CF_UNDERVLT];
					tmr_n[bcds_pkg::CF_DIS_DONE]  = cf_tmr[bcds_pkg::CF_DIS_DONE];
					if (cf_fire[bcds_pkg::CF_UNDERVLT]) begin
						phase_n = bcds_pkg::PH_IDLE;
						ev_n    = bcds_pkg::EV_UNDERVLT;
					end
					if (cf_fire[bcds_pkg::CF_DIS_DONE]) begin
						phase_n = bcds_pkg::PH_DIS_DONE;
						ev_n    = bcds_pkg::EV_DIS_DONE;
					end
				end
			end
			default: begin
				// Complete phases drop back to idle, lamps hold
				phase_n = bcds_pkg::PH_IDLE;
			end
		endcase
	end

	// Commit state on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= bcds_pkg::PH_IDLE;
			ov_q      <= bcds_pkg::RST_OVER_VOLT;
			uv_q      <= bcds_pkg::RST_UNDER_VOLT;
			duty_q    <= bcds_pkg::RST_PWM_DUTY;
			vsel_q    <= 1'b0;
			led_c_q   <= 1'b0;
			led_d_q   <= 1'b0;
			elapsed_q <= '0;
			wait_q    <= '0;
			for (int k = 0; k < NCF; k++) begin
				tmr_q[k] <= '0;
			end
		end else if (step) begin
			phase_q   <= phase_n;
			ov_q      <= ov_n;
			uv_q      <= uv_n;
			duty_q    <= duty_n;
			vsel_q    <= vsel_n;
			led_c_q   <= led_c_n;
			led_d_q   <= led_d_n;
			elapsed_q <= elapsed_n;
			wait_q    <= wait_n;
			tmr_q     <= tmr_n;
		end
	end

	// Build the result for this tick
	always_comb begin
		res.mode            = phase_n;
		res.charge_on       = (phase_n == bcds_pkg::PH_CHG);
		res.discharge_on    = (phase_n == bcds_pkg::PH_DIS);
		res.fan_on          = (phase_n == bcds_pkg::PH_DIS);
		res.charge_led      = led_c_n;
		res.discharge_led   = led_d_n;
		res.charge_volt_sel = vsel_n;
		res.charge_pwm_duty = duty_n;
		res.event_res       = ev_n;
	end

`ifndef SYNTH
	a_done_mode: assert property (@(posedge clk) disable iff (!arst_n)
		step && (ev_n == bcds_pkg::EV_CHG_DONE || ev_n == bcds_pkg::EV_DIS_DONE) |->
		(phase_n == bcds_pkg::PH_CHG_DONE || phase_n == bcds_pkg::PH_DIS_DONE))
		else $error("completion event without complete phase");

	a_done_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		step && (phase_q == bcds_pkg::PH_CHG_DONE || phase_q == bcds_pkg::PH_DIS_DONE) |=>
		(phase_q != bcds_pkg::PH_CHG_DONE && phase_q != bcds_pkg::PH_DIS_DONE))
		else $error("complete phase held past one tick");

	a_idle_wait: assert property (@(posedge clk) disable iff (!arst_n)
		!wait_q[bcds_pkg::CF_OVERVOLT] |-> (tmr_q[bcds_pkg::CF_OVERVOLT] == '0))
		else $error("disarmed confirm timer not cleared");

	a_stop_event: assert property (@(posedge clk) disable iff (!arst_n)
		step && (ev_n == bcds_pkg::EV_OVERVOLT || ev_n == bcds_pkg::EV_UNDERVLT) |->
		(phase_n == bcds_pkg::PH_IDLE))
		else $error("limit stop left phase active");
`endif

endmodule

// ----- rtl/battery_charge_discharge_supervisor.sv -----
// Path: an accepted input passes the input register, then the result register, which holds
// its result until it transfers. Throughput: one tick per cycle while results drain; the
// single-pass step logic takes one item each clock unless the result register stalls.
// A stalled result register holds one item while the input register takes the next.
// Reset (arst_n low, asynchronous): phase idle, default limits and registers, timers cleared,
// both channels empty.
module battery_charge_discharge_supervisor #(
	parameter int TIMER_WIDTH = bcds_pkg::TIMER_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [15:0]                    bat_volt_mv,
	input  logic [15:0]                    chg_current_ma,
	input  logic [15:0]                    dis_current_ma,
	input  logic                           req_start_charge,
	input  logic                           req_stop_charge,
	input  logic                           req_start_discharge,
	input  logic                           req_stop_discharge,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     mode,
	output logic                           charge_on,
	output logic                           discharge_on,
	output logic                           fan_on,
	output logic                           charge_led,
	output logic                           discharge_led,
	output logic                           charge_volt_sel,
	output logic [15:0]                    charge_pwm_duty,
	output logic [2:0]                     event_res,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bcds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);

	bcds_pkg::cfg_t    cfg;
	bcds_pkg::item_t   item_s1;
	logic              valid_s1;
	bcds_pkg::result_t res;
	bcds_pkg::result_t res_q;
	logic              out_valid_q;
	logic              advance;
	logic              step;

	bcds_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Move an item on when the result register is free or being drained
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{bat_volt_mv, chg_current_ma, dis_current_ma, req_start_charge,
				req_stop_charge, req_start_discharge, req_stop_discharge};
		end
	end

	bcds_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign mode            = res_q.mode;
	assign charge_on       = res_q.charge_on;
	assign discharge_on    = res_q.discharge_on;
	assign fan_on          = res_q.fan_on;
	assign charge_led      = res_q.charge_led;
	assign discharge_led   = res_q.discharge_led;
	assign charge_volt_sel = res_q.charge_volt_sel;
	assign charge_pwm_duty = res_q.charge_pwm_duty;
	assign event_res       = res_q.event_res;

`ifndef SYNTH
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("input taken while both stages are full");
`endif

endmodule

// ----- sim/battery_charge_discharge_supervisor_tb.sv -----
`timescale 1ns / 100ps

module battery_charge_discharge_supervisor_tb;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_TICKS = 180;

	// Battery type settings
	localparam logic [1:0] BT_HIGH = 2'd0;
	localparam logic [1:0] BT_MID  = 2'd1;
	localparam logic [1:0] BT_LOW  = 2'd2;
	localparam logic [1:0] BT_KEEP = 2'd3;

	typedef struct {
		bcds_pkg::item_t   it;
		bit                typed;
		bcds_pkg::result_t want;
		bit                retune;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	bcds_pkg::item_t tick_in = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] mode;
	logic charge_on, discharge_on, fan_on, charge_led, discharge_led, charge_volt_sel;
	logic [15:0] charge_pwm_duty;
	logic [2:0] event_res;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [bcds_pkg::CFG_IDX_W-1:0] cfg_index = bcds_pkg::CFG_BATTERY_TYPE;
	logic [15:0] cfg_data = '0;

	// Typed-in expectation for the tick on the bus
	bit row_typed = 1'b0;
	bcds_pkg::result_t row_want = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int mismatches = 0;
	int stall_cycles = 0;

	bcds_pkg::result_t pending_results[$];

	// Supervisor model: configuration
	logic [1:0]  cf_type = bcds_pkg::RST_BATTERY_TYPE;
	logic [15:0] cf_holdoff = bcds_pkg::RST_HOLDOFF;
	logic [15:0] cf_limit_cfm = bcds_pkg::RST_LIMIT_CONFIRM;
	logic [15:0] cf_cplt_cfm = bcds_pkg::RST_CPLT_CONFIRM;
	logic [15:0] cf_floor = bcds_pkg::RST_CURRENT_FLOOR;

	// Supervisor model: state
	logic [2:0]  ph = bcds_pkg::PH_IDLE;
	logic [15:0] ov_lim = bcds_pkg::RST_OVER_VOLT;
	logic [15:0] uv_lim = bcds_pkg::RST_UNDER_VOLT;
	logic [15:0] duty_lat = bcds_pkg::RST_PWM_DUTY;
	logic        vsel_lat = 1'b0;
	logic [15:0] elapsed = '0;
	bit          cf_armed [bcds_pkg::CF_COUNT];
	bit   [15:0] cf_count [bcds_pkg::CF_COUNT];
	logic        lamp_chg = 1'b0;
	logic        lamp_dis = 1'b0;

	battery_charge_discharge_supervisor uut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.bat_volt_mv         (tick_in.bat_volt_mv),
		.chg_current_ma      (tick_in.chg_current_ma),
		.dis_current_ma      (tick_in.dis_current_ma),
		.req_start_charge    (tick_in.req_start_charge),
		.req_stop_charge     (tick_in.req_stop_charge),
		.req_start_discharge (tick_in.req_start_discharge),
		.req_stop_discharge  (tick_in.req_stop_discharge),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.mode                (mode),
		.charge_on           (charge_on),
		.discharge_on        (discharge_on),
		.fan_on              (fan_on),
		.charge_led          (charge_led),
		.discharge_led       (discharge_led),
		.charge_volt_sel     (charge_volt_sel),
		.charge_pwm_duty     (charge_pwm_duty),
		.event_res           (event_res),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [15:0] sat_up(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic void clear_slots();
		for (int k = 0; k < bcds_pkg::CF_COUNT; k++) begin
			cf_armed[k] = 1'b0;
			cf_count[k] = '0;
		end
	endfunction

	// First tick of a condition arms the slot, later ticks count toward the limit
	function automatic bit confirm_slot(int k, bit cond, logic [15:0] lim);
		if (!cond) begin
			cf_armed[k] = 1'b0;
			cf_count[k] = '0;
			return 1'b0;
		end
		if (!cf_armed[k]) begin
			cf_armed[k] = 1'b1;
			cf_count[k] = '0;
			return 1'b0;
		end
		cf_count[k] = sat_up(cf_count[k]);
		if (cf_count[k] >= lim) begin
			cf_armed[k] = 1'b0;
			cf_count[k] = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the supervisor by one millisecond tick
	function automatic bcds_pkg::result_t supervise_tick(bcds_pkg::item_t it);
		bcds_pkg::result_t r;
		bit fresh;
		logic [2:0] ev;
		fresh = 1'b0;
		ev = bcds_pkg::EV_NONE;
		if (it.req_stop_discharge && (ph == bcds_pkg::PH_DIS || ph == bcds_pkg::PH_DIS_DONE))
			ph = bcds_pkg::PH_IDLE;
		if (it.req_stop_charge && (ph == bcds_pkg::PH_CHG || ph == bcds_pkg::PH_CHG_DONE))
			ph = bcds_pkg::PH_IDLE;
		if (it.req_start_charge && ph == bcds_pkg::PH_IDLE) begin
			case (cf_type)
				BT_HIGH: begin
					vsel_lat = 1'b0; duty_lat = 16'd24000;
					ov_lim = 16'd21500; uv_lim = 16'd12000;
				end
				BT_MID: begin
					vsel_lat = 1'b1; duty_lat = 16'd6000;
					ov_lim = 16'd17500; uv_lim = 16'd10000;
				end
				BT_LOW: begin
					vsel_lat = 1'b1; duty_lat = 16'd6000;
					ov_lim = 16'd15000; uv_lim = 16'd8500;
				end
				default: vsel_lat = 1'b0;
			endcase
			ph = bcds_pkg::PH_CHG;
			elapsed = '0;
			clear_slots();
			fresh = 1'b1;
		end
		if (it.req_start_discharge && ph == bcds_pkg::PH_IDLE) begin
			ph = bcds_pkg::PH_DIS;
			elapsed = '0;
			clear_slots();
			fresh = 1'b1;
		end
		case (ph)
			bcds_pkg::PH_IDLE: begin
				lamp_chg = 1'b0;
				lamp_dis = 1'b0;
				clear_slots();
			end
			bcds_pkg::PH_CHG: begin
				lamp_chg = 1'b1;
				lamp_dis = 1'b0;
				if (!fresh)
					elapsed = sat_up(elapsed);
				if (elapsed >= cf_holdoff) begin
					if (confirm_slot(bcds_pkg::CF_OVERVOLT, it.bat_volt_mv >= ov_lim &&
							it.chg_current_ma > cf_floor, cf_limit_cfm)) begin
						ph = bcds_pkg::PH_IDLE;
						ev = bcds_pkg::EV_OVERVOLT;
					end
					if (confirm_slot(bcds_pkg::CF_CHG_DONE, it.chg_current_ma <= cf_floor,
							cf_cplt_cfm)) begin
						ph = bcds_pkg::PH_CHG_DONE;
						ev = bcds_pkg::EV_CHG_DONE;
					end
				end
			end
			bcds_pkg::PH_DIS: begin
				lamp_chg = 1'b0;
				lamp_dis = 1'b1;
				if (!fresh)
					elapsed = sat_up(elapsed);
				if (elapsed >= cf_holdoff) begin
					if (confirm_slot(bcds_pkg::CF_UNDERVLT, it.bat_volt_mv <= uv_lim &&
							it.dis_current_ma > cf_floor, cf_limit_cfm)) begin
						ph = bcds_pkg::PH_IDLE;
						ev = bcds_pkg::EV_UNDERVLT;
					end
					if (confirm_slot(bcds_pkg::CF_DIS_DONE, it.dis_current_ma <= cf_floor,
							cf_cplt_cfm)) begin
						ph = bcds_pkg::PH_DIS_DONE;
						ev = bcds_pkg::EV_DIS_DONE;
					end
				end
			end
			default: ph = bcds_pkg::PH_IDLE;
		endcase
		r.mode = ph;
		r.charge_on = (ph == bcds_pkg::PH_CHG);
		r.discharge_on = (ph == bcds_pkg::PH_DIS);
		r.fan_on = (ph == bcds_pkg::PH_DIS);
		r.charge_led = lamp_chg;
		r.discharge_led = lamp_dis;
		r.charge_volt_sel = vsel_lat;
		r.charge_pwm_duty = duty_lat;
		r.event_res = ev;
		return r;
	endfunction

	function automatic bcds_pkg::item_t mk_tick(logic [15:0] v, logic [15:0] ic,
			logic [15:0] id, int sc, int pc, int sd, int pd);
		bcds_pkg::item_t it;
		it.bat_volt_mv = v;
		it.chg_current_ma = ic;
		it.dis_current_ma = id;
		it.req_start_charge = sc[0];
		it.req_stop_charge = pc[0];
		it.req_start_discharge = sd[0];
		it.req_stop_discharge = pd[0];
		return it;
	endfunction

	function automatic bcds_pkg::result_t mk_out(logic [2:0] md, int lc, int ld, int vs,
			logic [15:0] duty, logic [2:0] ev);
		bcds_pkg::result_t r;
		r.mode = md;
		r.charge_on = (md == bcds_pkg::PH_CHG);
		r.discharge_on = (md == bcds_pkg::PH_DIS);
		r.fan_on = (md == bcds_pkg::PH_DIS);
		r.charge_led = lc[0];
		r.discharge_led = ld[0];
		r.charge_volt_sel = vs[0];
		r.charge_pwm_duty = duty;
		r.event_res = ev;
		return r;
	endfunction

	function automatic script_row_t fixed_row(bcds_pkg::item_t it, bcds_pkg::result_t want);
		script_row_t s;
		s.it = it;
		s.typed = 1'b1;
		s.want = want;
		s.retune = 1'b0;
		return s;
	endfunction

	function automatic script_row_t open_row(bcds_pkg::item_t it);
		script_row_t s;
		s.it = it;
		s.typed = 1'b0;
		s.want = '0;
		s.retune = 1'b0;
		return s;
	endfunction

	function automatic logic [15:0] near(logic [15:0] center);
		return center + 16'($urandom_range(4)) - 16'd2;
	endfunction

	function automatic logic [15:0] pick_volt();
		case ($urandom_range(5))
			0: return near(ov_lim);
			1: return near(uv_lim);
			2: return 16'($urandom_range(16'hFFFF));
			3: return 16'd0;
			4: return 16'hFFFF;
			default: return 16'($urandom_range(uv_lim, ov_lim));
		endcase
	endfunction

	function automatic logic [15:0] pick_current();
		case ($urandom_range(5))
			0: return near(cf_floor);
			1: return 16'($urandom_range(16'hFFFF));
			2: return 16'd0;
			3: return 16'hFFFF;
			4: return cf_floor + 16'($urandom_range(2000));
			default: return 16'($urandom_range(cf_floor));
		endcase
	endfunction

	// Mostly sticky measurements near the limits, with sparse requests and some noise
	function automatic bcds_pkg::item_t next_tick(bcds_pkg::item_t prev);
		bcds_pkg::item_t it;
		it = prev;
		if ($urandom_range(99) < 15) begin
			it.bat_volt_mv = 16'($urandom_range(16'hFFFF));
			it.chg_current_ma = 16'($urandom_range(16'hFFFF));
			it.dis_current_ma = 16'($urandom_range(16'hFFFF));
			it.req_start_charge = 1'($urandom_range(1));
			it.req_stop_charge = 1'($urandom_range(1));
			it.req_start_discharge = 1'($urandom_range(1));
			it.req_stop_discharge = 1'($urandom_range(1));
			return it;
		end
		if ($urandom_range(9) < 3)
			it.bat_volt_mv = pick_volt();
		if ($urandom_range(9) < 3)
			it.chg_current_ma = pick_current();
		if ($urandom_range(9) < 3)
			it.dis_current_ma = pick_current();
		it.req_start_charge = ($urandom_range(9) == 0);
		it.req_start_discharge = ($urandom_range(9) == 0);
		it.req_stop_charge = ($urandom_range(19) == 0);
		it.req_stop_discharge = ($urandom_range(19) == 0);
		return it;
	endfunction

	function automatic int sender_gap();
		int g;
		g = 0;
		while ($urandom_range(99) < send_idle_pct)
			g++;
		return g;
	endfunction

	task automatic check_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			mismatches++;
			$display("%0t ns: %s expected %0d actual %0d", $time, name, want_v, got_v);
		end
	endtask

	// Offer one tick; entered and left at a falling edge
	task automatic offer(bcds_pkg::item_t it, bit typed, bcds_pkg::result_t want);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		tick_in <= it;
		row_typed <= typed;
		row_want <= want;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Drop the input and wait for every outstanding result
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(logic [bcds_pkg::CFG_IDX_W-1:0] idx, logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_config(logic [1:0] bt, logic [15:0] ho, logic [15:0] lc,
			logic [15:0] cc, logic [15:0] fl);
		cfg_write(bcds_pkg::CFG_BATTERY_TYPE, {14'd0, bt});
		cfg_write(bcds_pkg::CFG_HOLDOFF, ho);
		cfg_write(bcds_pkg::CFG_LIMIT_CONFIRM, lc);
		cfg_write(bcds_pkg::CFG_CPLT_CONFIRM, cc);
		cfg_write(bcds_pkg::CFG_CURRENT_FLOOR, fl);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Track register writes, predict accepted ticks, compare results
	always @(posedge clk) begin
		bcds_pkg::result_t seen;
		bcds_pkg::result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bcds_pkg::CFG_BATTERY_TYPE:  cf_type = cfg_data[1:0];
					bcds_pkg::CFG_HOLDOFF:       cf_holdoff = cfg_data;
					bcds_pkg::CFG_LIMIT_CONFIRM: cf_limit_cfm = cfg_data;
					bcds_pkg::CFG_CPLT_CONFIRM:  cf_cplt_cfm = cfg_data;
					bcds_pkg::CFG_CURRENT_FLOOR: cf_floor = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				seen = {mode, charge_on, discharge_on, fan_on, charge_led, discharge_led,
					charge_volt_sel, charge_pwm_duty, event_res};
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t ns: result transfer with nothing pending", $time);
				end else begin
					want = pending_results.pop_front();
					check_field("mode", int'(want.mode), int'(seen.mode));
					check_field("charge_on", int'(want.charge_on), int'(seen.charge_on));
					check_field("discharge_on", int'(want.discharge_on),
						int'(seen.discharge_on));
					check_field("fan_on", int'(want.fan_on), int'(seen.fan_on));
					check_field("charge_led", int'(want.charge_led), int'(seen.charge_led));
					check_field("discharge_led", int'(want.discharge_led),
						int'(seen.discharge_led));
					check_field("charge_volt_sel", int'(want.charge_volt_sel),
						int'(seen.charge_volt_sel));
					check_field("charge_pwm_duty", int'(want.charge_pwm_duty),
						int'(seen.charge_pwm_duty));
					check_field("event_res", int'(want.event_res), int'(seen.event_res));
				end
			end
			if (in_valid && in_ready) begin
				want = supervise_tick(tick_in);
				pending_results.push_back(row_typed ? row_want : want);
			end
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("battery_charge_discharge_supervisor: mismatch");
			$finish;
		end
	end

	initial begin
		script_row_t script[$];
		script_row_t s;
		bcds_pkg::item_t cur;

		// Reset settings: type high, long hold-off, so only request handling shows
		script.push_back(fixed_row(mk_tick(16'd0, 16'd0, 16'd0, 0, 0, 0, 0),
			mk_out(bcds_pkg::PH_IDLE, 0, 0, 0, bcds_pkg::RST_PWM_DUTY, bcds_pkg::EV_NONE)));
		script.push_back(fixed_row(mk_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1, 0, 1),
			mk_out(bcds_pkg::PH_IDLE, 0, 0, 0, bcds_pkg::RST_PWM_DUTY, bcds_pkg::EV_NONE)));
		script.push_back(fixed_row(mk_tick(16'hFFFF, 16'd0, 16'd0, 1, 0, 0, 0),
			mk_out(bcds_pkg::PH_CHG, 1, 0, 0, 16'd24000, bcds_pkg::EV_NONE)));
		script.push_back(fixed_row(mk_tick(16'd0, 16'hFFFF, 16'hFFFF, 0, 0, 1, 1),
			mk_out(bcds_pkg::PH_CHG, 1, 0, 0, 16'd24000, bcds_pkg::EV_NONE)));
		// stop charge and start discharge on one tick
		script.push_back(fixed_row(mk_tick(16'd0, 16'd0, 16'd0, 0, 1, 1, 0),
			mk_out(bcds_pkg::PH_DIS, 0, 1, 0, 16'd24000, bcds_pkg::EV_NONE)));
		// stop discharge and start charge on one tick
		script.push_back(fixed_row(mk_tick(16'd0, 16'd0, 16'd0, 1, 0, 0, 1),
			mk_out(bcds_pkg::PH_CHG, 1, 0, 0, 16'd24000, bcds_pkg::EV_NONE)));
		script.push_back(fixed_row(mk_tick(16'hFFFF, 16'hFFFF, 16'd0, 1, 1, 1, 1),
			mk_out(bcds_pkg::PH_CHG, 1, 0, 0, 16'd24000, bcds_pkg::EV_NONE)));
		script.push_back(fixed_row(mk_tick(16'hFFFF, 16'd0, 16'hFFFF, 0, 1, 0, 0),
			mk_out(bcds_pkg::PH_IDLE, 0, 0, 0, 16'd24000, bcds_pkg::EV_NONE)));
		// Short timers, no hold-off: checks run on the start tick
		s = fixed_row(mk_tick(16'd17500, 16'd301, 16'd0, 1, 0, 0, 0),
			mk_out(bcds_pkg::PH_CHG, 1, 0, 1, 16'd6000, bcds_pkg::EV_NONE));
		s.retune = 1'b1;
		script.push_back(s);
		script.push_back(open_row(mk_tick(16'd17500, 16'd301, 16'd0, 0, 0, 0, 0)));
		script.push_back(fixed_row(mk_tick(16'd17500, 16'd301, 16'd0, 0, 0, 0, 0),
			mk_out(bcds_pkg::PH_IDLE, 1, 0, 1, 16'd6000, bcds_pkg::EV_OVERVOLT)));
		script.push_back(open_row(mk_tick(16'd0, 16'd0, 16'd0, 0, 0, 0, 0)));
		script.push_back(open_row(mk_tick(16'd0, 16'd300, 16'd0, 1, 0, 0, 0)));
		script.push_back(open_row(mk_tick(16'hFFFF, 16'd0, 16'd0, 0, 0, 0, 0)));
		script.push_back(open_row(mk_tick(16'hFFFF, 16'd0, 16'd0, 0, 0, 0, 0)));
		script.push_back(fixed_row(mk_tick(16'hFFFF, 16'd0, 16'd0, 0, 0, 0, 0),
			mk_out(bcds_pkg::PH_CHG_DONE, 1, 0, 1, 16'd6000, bcds_pkg::EV_CHG_DONE)));
		// complete phase falls back to idle, start request ignored meanwhile
		script.push_back(open_row(mk_tick(16'd0, 16'd0, 16'd0, 0, 0, 1, 0)));
		script.push_back(open_row(mk_tick(16'd10000, 16'd0, 16'd301, 0, 0, 1, 0)));
		script.push_back(open_row(mk_tick(16'd10000, 16'd0, 16'd301, 0, 0, 0, 0)));
		script.push_back(fixed_row(mk_tick(16'd10000, 16'd0, 16'd301, 0, 0, 0, 0),
			mk_out(bcds_pkg::PH_IDLE, 0, 1, 1, 16'd6000, bcds_pkg::EV_UNDERVLT)));
		script.push_back(open_row(mk_tick(16'd0, 16'd0, 16'd0, 0, 0, 1, 0)));
		script.push_back(open_row(mk_tick(16'd0, 16'd0, 16'd0, 0, 0, 0, 0)));
		script.push_back(open_row(mk_tick(16'd0, 16'd0, 16'd0, 0, 0, 0, 0)));
		script.push_back(fixed_row(mk_tick(16'd0, 16'd0, 16'd0, 0, 0, 0, 0),
			mk_out(bcds_pkg::PH_DIS_DONE, 0, 1, 1, 16'd6000, bcds_pkg::EV_DIS_DONE)));
		script.push_back(open_row(mk_tick(16'd0, 16'd0, 16'd0, 0, 1, 0, 1)));

		// Hold reset, release at a falling edge
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].retune) begin
				settle();
				set_config(BT_MID, 16'd0, 16'd2, 16'd3, 16'd300);
			end
			offer(script[i].it, script[i].typed, script[i].want);
		end

		// Random phases, each under its own settings and handshake pressure
		cur = mk_tick(16'd0, 16'd0, 16'd0, 0, 0, 0, 0);
		for (int p = 0; p < 4; p++) begin
			settle();
			case (p)
				0: begin
					set_config(BT_LOW, 16'd3, 16'd4, 16'd5, 16'd1000);
					send_idle_pct = 0;
					recv_stall_pct = 0;
					hold_req = 1'b1;
				end
				1: begin
					set_config(BT_KEEP, 16'd0, 16'd0, 16'd1, 16'd0);
					send_idle_pct = 86;
					recv_stall_pct = 0;
				end
				2: begin
					set_config(BT_HIGH, 16'd1, 16'hFFFF, 16'd2, 16'hFFFF);
					send_idle_pct = 0;
					recv_stall_pct = 86;
				end
				default: begin
					set_config(BT_MID, 16'd2, 16'd3, 16'd0, 16'd300);
					send_idle_pct = 6;
					recv_stall_pct = 6;
				end
			endcase
			repeat (PHASE_TICKS) begin
				cur = next_tick(cur);
				offer(cur, 1'b0, '0);
			end
		end

		// Longest hold-off: no check runs while the phase clock counts
		settle();
		set_config(BT_HIGH, 16'hFFFF, 16'd2, 16'd2, 16'd300);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		offer(mk_tick(16'd15000, 16'd1000, 16'd0, 1, 0, 0, 0), 1'b0, '0);
		repeat (3)
			offer(mk_tick(16'hFFFF, 16'd0, 16'd0, 0, 0, 0, 0), 1'b0, '0);
		offer(mk_tick(16'd0, 16'd0, 16'd0, 0, 0, 0, 0), 1'b0, '0);

		// Drain and finish
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("battery_charge_discharge_supervisor: match");
		else
			$display("battery_charge_discharge_supervisor: mismatch");
		$finish;
	end

endmodule
